>>> src/protobuf_field_parser_core_macros.svh
// Assertion macros for the protobuf field parser.
// Included by modules that check their own control logic; needs clk and rst_n in scope.
`ifndef PROTOBUF_FIELD_PARSER_CORE_MACROS_SVH
`define PROTOBUF_FIELD_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define PFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pfp_pkg.sv
// Package for the protobuf field parser: widths, phase and status codes, result word type.
// No dependencies.
package pfp_pkg;

    localparam int MAX_BUFFER_BYTES_DEF = 256;
    localparam int POS_W    = 9;
    localparam int FNUM_W   = 32;
    localparam int VAL_W    = 64;
    localparam int SHIFT_W  = 7;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USED_W = FNUM_W + VAL_W + POS_W + STAT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
    localparam logic [2:0] WIRE_MASK    = 3'h7;
    localparam int         TAG_SHIFT    = 3;
    localparam logic [SHIFT_W-1:0] SHIFT_STEP  = 7'd7;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 7'd64;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_DELIM  = 3'd2;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_VALUE  = 5'b00010,
        PH_LENGTH = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_STOP   = 5'b10000
    } phase_t;

    typedef enum logic [STAT_W-1:0] {
        ST_CLEAN   = 2'd0,
        ST_BADWIRE = 2'd1,
        ST_OVERRUN = 2'd2,
        ST_TAGCUT  = 2'd3
    } status_t;

    localparam logic [KIND_W-1:0] KIND_VARINT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEN    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FNUM_W-1:0] fld_num;
        logic [VAL_W-1:0]  field_value;
        logic [POS_W-1:0]  payload_offset;
        logic [STAT_W-1:0] end_status;
        logic              run_last;
    } result_t;

endpackage

>>> src/protobuf_field_parser_core.sv
// Protobuf top-level field parser: byte-serial tag/varint decoder with a result queue.
// Depends on pfp_pkg and protobuf_field_parser_core_macros.svh.
//
// Input channel s_axis: one buffer byte per word, tlast on the final byte of a buffer.
// Output channel m_axis: one field or closing word per transfer, tuser holds the kind,
// tlast marks the last word caused by an input byte.
// Each byte is decoded in the cycle it is accepted; its results enter a 4-word queue
// and leave through m_axis in order. A byte yields at most two words (a field and
// the closing word). With the receiver taking every word the block accepts one byte
// per cycle; s_axis_tready drops while more than two words are queued, so a stalled
// receiver holds the input back once three or four words wait.
// The closing word on the last byte reports the buffer status (0 clean, 1 bad wire
// type, 2 length overrun, 3 tag cut) and the parser then returns to its reset state.
// Reset empties the queue and clears all parse state; no clearing pass is needed.
module protobuf_field_parser_core
    import pfp_pkg::*;
#(
    parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // byte_value[7:0], buffer_length[16:8]
    input  logic                  s_axis_tlast,  // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // field_number, field_value,
                                                 // payload_offset, end_status
    output logic [KIND_W-1:0]     m_axis_tuser,  // item_kind
    output logic                  m_axis_tlast   // run_last
);

`include "protobuf_field_parser_core_macros.svh"

    phase_t              phase_reg, phase_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [SHIFT_W-1:0]  shift_reg, shift_next;
    logic [FNUM_W-1:0]   fnum_reg, fnum_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    skip_reg, skip_next;
    status_t             stat_reg, stat_next;

    result_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    logic [7:0]          byte_in;
    logic [POS_W-1:0]    blen_in, blen_c;
    logic                more, in_acc, pop;
    logic [VAL_W-1:0]    acc_g;
    logic [SHIFT_W-1:0]  shift_g;
    logic [POS_W:0]      endp, room;
    logic                field_vld;
    result_t             field_res, close_res, wr0_res;
    status_t             close_st;
    logic [1:0]          push_n;

    assign byte_in = s_axis_tdata[7:0];
    assign blen_in = s_axis_tdata[16:8];
    assign more    = byte_in[7];
    assign blen_c  = (32'(blen_in) > MAX_BUFFER_BYTES) ? POS_W'(MAX_BUFFER_BYTES) : blen_in;
    assign endp    = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign room    = {1'b0, blen_c} - endp;

    assign s_axis_tready = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        if (shift_reg < SHIFT_LIMIT)
        begin
            acc_g   = acc_reg | (VAL_W'(byte_in[6:0] & PAYLOAD_MASK) << shift_reg);
            shift_g = shift_reg + SHIFT_STEP;
        end
        else
        begin
            acc_g   = acc_reg;
            shift_g = shift_reg;
        end

        phase_next = phase_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        fnum_next  = fnum_reg;
        skip_next  = skip_reg;
        stat_next  = stat_reg;
        pos_next   = pos_reg + POS_W'(1);
        field_vld  = 1'b0;
        field_res  = '0;

        unique case (phase_reg)
            PH_TAG:
            begin
                acc_next   = acc_g;
                shift_next = shift_g;
                if (!more)
                begin
                    fnum_next  = acc_g[TAG_SHIFT +: FNUM_W];
                    acc_next   = '0;
                    shift_next = '0;
                    if ((acc_g[2:0] & WIRE_MASK) == WIRE_VARINT)
                        phase_next = PH_VALUE;
                    else if ((acc_g[2:0] & WIRE_MASK) == WIRE_DELIM)
                        phase_next = PH_LENGTH;
                    else
                    begin
                        phase_next = PH_STOP;
                        stat_next  = ST_BADWIRE;
                    end
                    if (s_axis_tlast && (phase_next != PH_STOP))
                    begin
                        phase_next = PH_STOP;
                        stat_next  = ST_TAGCUT;
                    end
                end
                else if (s_axis_tlast)
                begin
                    phase_next = PH_STOP;
                    stat_next  = ST_TAGCUT;
                end
            end
            PH_VALUE:
            begin
                acc_next   = acc_g;
                shift_next = shift_g;
                if (!more || s_axis_tlast)
                begin
                    field_vld                = 1'b1;
                    field_res.kind           = KIND_VARINT;
                    field_res.fld_num        = fnum_reg;
                    field_res.field_value    = acc_g;
                    acc_next                 = '0;
                    shift_next               = '0;
                    phase_next               = PH_TAG;
                end
            end
            PH_LENGTH:
            begin
                acc_next   = acc_g;
                shift_next = shift_g;
                if (!more || s_axis_tlast)
                begin
                    acc_next   = '0;
                    shift_next = '0;
                    if ((endp > {1'b0, blen_c}) || (acc_g > VAL_W'(room)))
                    begin
                        phase_next = PH_STOP;
                        stat_next  = ST_OVERRUN;
                    end
                    else
                    begin
                        field_vld                = 1'b1;
                        field_res.kind           = KIND_LEN;
                        field_res.fld_num        = fnum_reg;
                        field_res.field_value    = acc_g;
                        field_res.payload_offset = endp[POS_W-1:0];
                        skip_next                = acc_g[POS_W-1:0];
                        phase_next = (acc_g[POS_W-1:0] == '0) ? PH_TAG : PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - POS_W'(1);
                if (skip_next == '0)
                    phase_next = PH_TAG;
            end
            PH_STOP:
            begin
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        close_st = stat_next;
        if ((phase_next == PH_SKIP) && (skip_next != '0))
            close_st = ST_OVERRUN;
        close_res            = '0;
        close_res.kind       = KIND_CLOSE;
        close_res.end_status = close_st;
        close_res.run_last   = 1'b1;

        field_res.run_last = !s_axis_tlast;

        if (s_axis_tlast)
        begin
            phase_next = PH_TAG;
            acc_next   = '0;
            shift_next = '0;
            fnum_next  = '0;
            pos_next   = '0;
            skip_next  = '0;
            stat_next  = ST_CLEAN;
        end

        wr0_res = field_vld ? field_res : close_res;
        push_n  = in_acc ? (2'(field_vld) + 2'(s_axis_tlast)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            acc_reg    <= '0;
            shift_reg  <= '0;
            fnum_reg   <= '0;
            pos_reg    <= '0;
            skip_reg   <= '0;
            stat_reg   <= ST_CLEAN;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                shift_reg <= shift_next;
                fnum_reg  <= fnum_next;
                pos_reg   <= pos_next;
                skip_reg  <= skip_next;
                stat_reg  <= stat_next;
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= wr0_res;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= close_res;
    end

    assign m_axis_tdata = {(OUT_DATA_W - OUT_USED_W)'(0),
                           queue_reg[rd_ptr_reg].end_status,
                           queue_reg[rd_ptr_reg].payload_offset,
                           queue_reg[rd_ptr_reg].field_value,
                           queue_reg[rd_ptr_reg].fld_num};
    assign m_axis_tuser = queue_reg[rd_ptr_reg].kind;
    assign m_axis_tlast = queue_reg[rd_ptr_reg].run_last;

    `PFP_ASSERT_NOW(a_queue_bound, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "result queue overflow")
    `PFP_ASSERT_NOW(a_accept_room, in_acc, cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2), "byte taken without queue room")
    `PFP_ASSERT_NEXT(a_last_resets, in_acc && s_axis_tlast, (phase_reg == PH_TAG) && (pos_reg == '0) && (stat_reg == ST_CLEAN), "parser not reset after last byte")
    `PFP_ASSERT_NOW(a_stop_status, phase_reg == PH_STOP, stat_reg != ST_CLEAN, "stopped with clean status")
    `PFP_ASSERT_NOW(a_skip_nonzero, phase_reg == PH_SKIP, skip_reg != '0, "skip phase with zero count")

endmodule
